// ===== src/led_progress_chaser_blend_top_defines.svh =====
// ----------------------------------------------------------------------------
// LED comet chaser assertion macros
// Macros for the concurrent checks on the chaser's color stream port.
// ----------------------------------------------------------------------------
`ifndef LED_PROGRESS_CHASER_BLEND_TOP_DEFINES_SVH
`define LED_PROGRESS_CHASER_BLEND_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPCB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("chaser check failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent.
`define LPCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chaser check failed: next-cycle property");

`endif

// ===== src/lpcb_pkg.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser package
// Widths, register codes, shared structs and the color channel helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcb_pkg;

    localparam int WORD_W    = 32;
    localparam int CNT_W     = 7;
    localparam int LED_IDX_W = 6;
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W   = 32;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Register reset values.
    localparam logic [WORD_W-1:0]  SPEED_RST      = 32'h0001_0000;
    localparam logic [WORD_W-1:0]  PHASE_RST      = 32'h0000_0000;
    localparam logic [CNT_W-1:0]   COUNT_RST      = 7'd60;
    localparam logic [COLOR_W-1:0] HEAD_COLOR_RST = 24'hFF_FFFF;
    localparam logic [COLOR_W-1:0] TAIL_COLOR_RST = 24'h00_00FF;
    localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 24'h00_0000;

    // Channel positions within a packed color.
    localparam int RED_LSB   = 16;
    localparam int GREEN_LSB = 8;
    localparam int BLUE_LSB  = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED      = 3'd0,
        CFG_PHASE      = 3'd1,
        CFG_LED_COUNT  = 3'd2,
        CFG_HEAD_COLOR = 3'd3,
        CFG_TAIL_COLOR = 3'd4,
        CFG_BG_COLOR   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0]  speed;
        logic [WORD_W-1:0]  phase_shift;
        logic [CNT_W-1:0]   led_count;
        logic [COLOR_W-1:0] head_color;
        logic [COLOR_W-1:0] tail_color;
        logic [COLOR_W-1:0] bg_color;
    } cfg_t;

    // One frame as classified by the front end.
    typedef struct packed {
        logic [LED_IDX_W-1:0] head;
        logic [LED_IDX_W-1:0] prev;
        logic [LED_IDX_W-1:0] last;
        logic                 tail_en;
        logic [COLOR_W-1:0]   head_blend;
        logic [COLOR_W-1:0]   prev_blend;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] color, input int lsb);
        return color[lsb +: CH_W];
    endfunction

endpackage

`default_nettype wire

// ===== src/lpcb_regs.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser configuration registers
// Holds the six settings and decodes the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcb_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lpcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpcb_pkg::WORD_W-1:0]    cfg_wr_data,
    output lpcb_pkg::cfg_t                      cfg
);
    import lpcb_pkg::*;

    cfg_t cfg_reg;

    // Register write decode; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed       <= SPEED_RST;
            cfg_reg.phase_shift <= PHASE_RST;
            cfg_reg.led_count   <= COUNT_RST;
            cfg_reg.head_color  <= HEAD_COLOR_RST;
            cfg_reg.tail_color  <= TAIL_COLOR_RST;
            cfg_reg.bg_color    <= BG_COLOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPEED:      cfg_reg.speed       <= cfg_wr_data;
                CFG_PHASE:      cfg_reg.phase_shift <= cfg_wr_data;
                CFG_LED_COUNT:  cfg_reg.led_count   <= cfg_wr_data[CNT_W-1:0];
                CFG_HEAD_COLOR: cfg_reg.head_color  <= cfg_wr_data[COLOR_W-1:0];
                CFG_TAIL_COLOR: cfg_reg.tail_color  <= cfg_wr_data[COLOR_W-1:0];
                CFG_BG_COLOR:   cfg_reg.bg_color    <= cfg_wr_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/lpcb_front.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser front end
// Four-stage pipeline that turns a frame time into a frame descriptor:
// head position, blend fraction and the two blended colors.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcb_front #(
    parameter int MAX_LEDS      = 64,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  lpcb_pkg::cfg_t                   cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [lpcb_pkg::WORD_W-1:0] in_time,
    output logic                             q_push,
    output lpcb_pkg::desc_t                  q_wdata,
    input  lpcb_pkg::qstat_t                 q_stat
);
    import lpcb_pkg::*;

    localparam int BW = FRACTION_BITS + 10;
    localparam int SW = FRACTION_BITS + CNT_W;

    // Rounded blend of one channel: a + (b - a) * f, ties rounded up.
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [FRACTION_BITS-1:0] f);
        logic [BW-1:0] base;
        logic [BW-1:0] diff;
        logic [BW-1:0] prod;
        logic [BW-1:0] total;
        base  = {2'b00, a, {FRACTION_BITS{1'b0}}};
        diff  = BW'({1'b0, b}) - BW'({1'b0, a});
        prod  = diff * BW'(f);
        total = base + prod + (BW'(1) << (FRACTION_BITS - 1));
        return total[FRACTION_BITS +: CH_W];
    endfunction

    function automatic logic [COLOR_W-1:0] blend_color(input logic [COLOR_W-1:0] ca,
                                                       input logic [COLOR_W-1:0] cb,
                                                       input logic [FRACTION_BITS-1:0] f);
        return {blend_ch(chan(ca, RED_LSB),   chan(cb, RED_LSB),   f),
                blend_ch(chan(ca, GREEN_LSB), chan(cb, GREEN_LSB), f),
                blend_ch(chan(ca, BLUE_LSB),  chan(cb, BLUE_LSB),  f)};
    endfunction

    logic                     adv;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [WORD_W-1:0]        sum_s1_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         count_s1_reg, count_s2_reg;
    logic [2*WORD_W-1:0]      prod_next;
    logic [FRACTION_BITS-1:0] pos_s2_reg;
    logic [SW-1:0]            scaled_next;
    logic [LED_IDX_W-1:0]     head_s3_reg;
    logic [FRACTION_BITS-1:0] frac_s3_reg;
    logic [LED_IDX_W-1:0]     last_s3_reg;
    desc_t                    desc_next;
    desc_t                    desc_reg;

    // The whole pipeline moves unless a finished descriptor waits on a full queue.
    assign adv      = !v4_reg || !q_stat.full;
    assign in_ready = adv;
    assign q_push   = v4_reg && !q_stat.full;
    assign q_wdata  = desc_reg;

    // LED count clamped to the range of one up to the strip length.
    always_comb begin
        if (cfg.led_count == '0) begin
            count_next = CNT_W'(1);
        end else if (cfg.led_count > CNT_W'(MAX_LEDS)) begin
            count_next = CNT_W'(MAX_LEDS);
        end else begin
            count_next = cfg.led_count;
        end
    end

    // Frame position is the fraction of the scaled time; head and blend
    // fraction come from the position times the LED count.
    assign prod_next   = {{WORD_W{1'b0}}, sum_s1_reg} * {{WORD_W{1'b0}}, cfg.speed};
    assign scaled_next = SW'(pos_s2_reg) * SW'(count_s2_reg);

    // The LED before the head wraps to the last LED when the head is LED zero.
    always_comb begin
        desc_next.head       = head_s3_reg;
        desc_next.prev       = (head_s3_reg == '0) ? last_s3_reg
                                                   : head_s3_reg - LED_IDX_W'(1);
        desc_next.last       = last_s3_reg;
        desc_next.tail_en    = (head_s3_reg != '0);
        desc_next.head_blend = blend_color(cfg.bg_color, cfg.head_color, frac_s3_reg);
        desc_next.prev_blend = blend_color(cfg.head_color, cfg.tail_color, frac_s3_reg);
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_s1_reg   <= in_time + cfg.phase_shift;
            count_s1_reg <= count_next;
            pos_s2_reg   <= prod_next[FRACTION_BITS +: FRACTION_BITS];
            count_s2_reg <= count_s1_reg;
            head_s3_reg  <= scaled_next[FRACTION_BITS +: LED_IDX_W];
            frac_s3_reg  <= scaled_next[FRACTION_BITS-1:0];
            last_s3_reg  <= LED_IDX_W'(count_s2_reg - CNT_W'(1));
            desc_reg     <= desc_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lpcb_queue.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser descriptor queue
// Short first-in first-out buffer between the front end and the LED sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcb_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  lpcb_pkg::desc_t  wdata,
    input  wire logic        pop,
    output lpcb_pkg::desc_t  rdata,
    output lpcb_pkg::qstat_t stat
);
    import lpcb_pkg::*;

    desc_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign stat.full  = (fill_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (fill_reg == '0);
    assign rdata      = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/lpcb_back.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser back end
// Sweeps the LEDs of the frame at the queue head into the output register, one color per
// cycle while the queue holds a frame and the output register is empty or drained.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcb_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  lpcb_pkg::cfg_t                    cfg,
    input  lpcb_pkg::desc_t                   q_rdata,
    input  lpcb_pkg::qstat_t                  q_stat,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [lpcb_pkg::LED_IDX_W-1:0]    out_index,
    output logic [lpcb_pkg::COLOR_W-1:0]      out_color,
    output logic                              out_last
);
    import lpcb_pkg::*;

    logic                 adv;
    logic                 load;
    logic                 at_last;
    logic [LED_IDX_W-1:0] idx_reg;
    logic [COLOR_W-1:0]   color_next;
    logic                 valid_reg;
    logic [LED_IDX_W-1:0] index_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic                 last_reg;

    // The output register takes a new color whenever it is empty or drained and the queue holds a frame.
    assign adv     = !valid_reg || out_ready;
    assign load    = adv && !q_stat.empty;
    assign at_last = (idx_reg == q_rdata.last);
    assign q_pop   = load && at_last;

    // Color of the current LED: head blend wins over the LED before it.
    always_comb begin
        if (idx_reg == q_rdata.head) begin
            color_next = q_rdata.head_blend;
        end else if (idx_reg == q_rdata.prev) begin
            color_next = q_rdata.prev_blend;
        end else if (q_rdata.tail_en && (idx_reg < q_rdata.prev)) begin
            color_next = cfg.tail_color;
        end else begin
            color_next = cfg.bg_color;
        end
    end

    // LED counter and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (adv) begin
                valid_reg <= !q_stat.empty;
            end
            if (load) begin
                idx_reg <= at_last ? '0 : idx_reg + LED_IDX_W'(1);
            end
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            index_reg <= idx_reg;
            color_reg <= color_next;
            last_reg  <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_color = color_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ===== src/led_progress_chaser_blend_top.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser with fade, top level
// Path: a frame time passes the front pipeline and the descriptor queue into the output register.
// Throughput: one LED color per cycle while the receiver is ready and a frame waits, one color per LED,
// and the front pipeline takes a frame time every cycle while the two-frame queue has room.
// Reset: synchronous and active low; registers return to their defaults, pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none

module led_progress_chaser_blend_top #(
    parameter int MAX_LEDS      = 64,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Frame time stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lpcb_pkg::WORD_W-1:0]    s_tdata,     // [31:0] frame_time
    // LED color stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lpcb_pkg::TDATA_W-1:0]        m_tdata,     // [5:0] led_index, [13:6] red,
                                                             // [21:14] green, [29:22] blue
    output logic                                m_tlast,     // last_led
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [lpcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpcb_pkg::WORD_W-1:0]    cfg_wr_data
);
    import lpcb_pkg::*;

    cfg_t                 cfg;
    logic                 q_push;
    logic                 q_pop;
    desc_t                q_wdata;
    desc_t                q_rdata;
    qstat_t               q_stat;
    logic [LED_IDX_W-1:0] out_index;
    logic [COLOR_W-1:0]   out_color;

    lpcb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lpcb_front #(
        .MAX_LEDS      (MAX_LEDS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_time  (s_tdata),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_stat   (q_stat)
    );

    lpcb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    lpcb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_rdata   (q_rdata),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_color (out_color),
        .out_last  (m_tlast)
    );

    // Pack the color transfer, index in the lowest bits.
    assign m_tdata = {2'b00,
                      chan(out_color, BLUE_LSB),
                      chan(out_color, GREEN_LSB),
                      chan(out_color, RED_LSB),
                      out_index};

endmodule

`default_nettype wire

// ===== src/lpcb_checker.sv =====
// ----------------------------------------------------------------------------
// LED comet chaser port checker
// Watches the color stream for held stalls and for gap-free LED sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_progress_chaser_blend_top_defines.svh"

module lpcb_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [lpcb_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);
    import lpcb_pkg::*;

    logic                 stall;
    logic                 xfer;
    logic [LED_IDX_W-1:0] led_idx;

    // Handshake views and the LED index field of the color transfer.
    assign stall   = m_tvalid && !m_tready;
    assign xfer    = m_tvalid && m_tready;
    assign led_idx = m_tdata[LED_IDX_W-1:0];

    // A stalled color transfer keeps its contents.
    `LPCB_ASSERT_NEXT(a_stall_hold, stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Within a frame the next LED color follows without a gap.
    `LPCB_ASSERT_NEXT(a_sweep_gapless, xfer && !m_tlast, m_tvalid)

    // Within a frame the LED index counts up by one.
    `LPCB_ASSERT_NEXT(a_sweep_step, xfer && !m_tlast, led_idx == $past(led_idx) + LED_IDX_W'(1))

    // A new frame starts at LED zero.
    `LPCB_ASSERT_NEXT(a_frame_restart, xfer && m_tlast, !m_tvalid || (led_idx == '0))

endmodule

bind led_progress_chaser_blend_top lpcb_checker u_lpcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED comet chaser testbench
// Feeds frame times into the chaser and checks every LED color it emits
// against an in-bench model of the comet, across several register settings.
// ----------------------------------------------------------------------------

module tb_top;

    import lpcb_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 6;
    localparam int FRAC = 16;
    localparam int LED_MAX = 64;
    localparam int IDLE_PCT = 18;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_PHASES = 6;
    localparam int FRAMES_PER_PHASE = 27;
    localparam int MAX_REPORTS = 10;

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

    // One row of the directed plan. A frame row may carry a known pattern:
    // count LEDs, LED a in color ca, LED b in color cb, every other LED in rest.
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    value;
        logic                 known;
        logic [CNT_W-1:0]     n;
        logic [LED_IDX_W-1:0] a;
        logic [COLOR_W-1:0]   ca;
        logic [LED_IDX_W-1:0] b;
        logic [COLOR_W-1:0]   cb;
        logic [COLOR_W-1:0]   rest;
    } plan_row_t;

    // One LED color as it leaves the block.
    typedef struct packed {
        logic [LED_IDX_W-1:0] idx;
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic                 last;
    } led_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_wr_data = '0;

    // Shadow copy of the registers, as the block should hold them.
    logic [WORD_W-1:0]     sh_speed = SPEED_RST;
    logic [WORD_W-1:0]     sh_phase = PHASE_RST;
    logic [CNT_W-1:0]      sh_count = COUNT_RST;
    logic [COLOR_W-1:0]    sh_head = HEAD_COLOR_RST;
    logic [COLOR_W-1:0]    sh_tail = TAIL_COLOR_RST;
    logic [COLOR_W-1:0]    sh_bg = BG_COLOR_RST;

    led_px_t               colors_due[$];
    plan_row_t             plan[$];
    int                    bad_count = 0;
    int                    cycle_count = 0;
    logic                  idle_on = 1'b1;
    int                    hold_ask = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;

    led_progress_chaser_blend_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Rounded blend of one channel: a + (b - a) * f, ties rounded up.
    function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                                    logic [FRAC-1:0] f);
        logic [31:0] v;
        v = 32'(a) * ((32'd1 << FRAC) - 32'(f)) + 32'(b) * 32'(f) + (32'd1 << (FRAC - 1));
        return v[FRAC +: CH_W];
    endfunction

    function automatic logic [COLOR_W-1:0] mix_color(logic [COLOR_W-1:0] ca,
                                                     logic [COLOR_W-1:0] cb,
                                                     logic [FRAC-1:0] f);
        return {mix_channel(ca[23:16], cb[23:16], f),
                mix_channel(ca[15:8], cb[15:8], f),
                mix_channel(ca[7:0], cb[7:0], f)};
    endfunction

    function automatic void push_color(int i, int n, logic [COLOR_W-1:0] c);
        led_px_t px;
        px.idx   = LED_IDX_W'(i);
        px.red   = c[23:16];
        px.green = c[15:8];
        px.blue  = c[7:0];
        px.last  = (i == n - 1);
        colors_due.push_back(px);
    endfunction

    // Works out the comet for one frame time and queues every LED color.
    function automatic void chase_frame(logic [WORD_W-1:0] t);
        logic [WORD_W-1:0]    sum;
        logic [63:0]          prod;
        logic [FRAC-1:0]      pos;
        logic [31:0]          scaled;
        logic [FRAC-1:0]      f;
        logic [COLOR_W-1:0]   c;
        int                   n;
        int                   head;
        int                   prev;
        n = int'(sh_count);
        if (n < 1) n = 1;
        if (n > LED_MAX) n = LED_MAX;
        sum    = t + sh_phase;
        prod   = 64'(sum) * 64'(sh_speed);
        pos    = prod[FRAC +: FRAC];
        scaled = 32'(pos) * 32'(n);
        head   = int'(scaled >> FRAC);
        f      = scaled[FRAC-1:0];
        prev   = (head == 0) ? n - 1 : head - 1;
        for (int i = 0; i < n; i++) begin
            if (i == head) begin
                c = mix_color(sh_bg, sh_head, f);
            end else if (i == prev) begin
                c = mix_color(sh_head, sh_tail, f);
            end else if (head >= 1 && i < head - 1) begin
                c = sh_tail;
            end else begin
                c = sh_bg;
            end
            push_color(i, n, c);
        end
    endfunction

    // Queues a pattern that was worked out by hand.
    function automatic void push_pattern(plan_row_t row);
        logic [COLOR_W-1:0] c;
        for (int i = 0; i < int'(row.n); i++) begin
            if (i == int'(row.a)) begin
                c = row.ca;
            end else if (i == int'(row.b)) begin
                c = row.cb;
            end else begin
                c = row.rest;
            end
            push_color(i, int'(row.n), c);
        end
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
        plan_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.value = v;
        return row;
    endfunction

    function automatic plan_row_t frame_row(logic [WORD_W-1:0] t);
        plan_row_t row;
        row = '0;
        row.kind = ROW_FRAME;
        row.value = t;
        return row;
    endfunction

    function automatic plan_row_t known_row(logic [WORD_W-1:0] t, logic [CNT_W-1:0] n,
                                            logic [LED_IDX_W-1:0] a, logic [COLOR_W-1:0] ca,
                                            logic [LED_IDX_W-1:0] b, logic [COLOR_W-1:0] cb,
                                            logic [COLOR_W-1:0] rest);
        plan_row_t row;
        row = frame_row(t);
        row.known = 1'b1;
        row.n = n;
        row.a = a;
        row.ca = ca;
        row.b = b;
        row.cb = cb;
        row.rest = rest;
        return row;
    endfunction

    function automatic logic [WORD_W-1:0] pick_color();
        if ($urandom_range(4) == 0) begin
            return $urandom_range(1) ? 32'h00FF_FFFF : 32'h0;
        end
        return $urandom;
    endfunction

    // Writes one register and mirrors it in the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        case (idx)
            CFG_SPEED:      sh_speed = v;
            CFG_PHASE:      sh_phase = v;
            CFG_LED_COUNT:  sh_count = v[CNT_W-1:0];
            CFG_HEAD_COLOR: sh_head = v[COLOR_W-1:0];
            CFG_TAIL_COLOR: sh_tail = v[COLOR_W-1:0];
            CFG_BG_COLOR:   sh_bg = v[COLOR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one frame time, with random gaps, and queues its colors on transfer.
    task automatic send_frame(plan_row_t row);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.value;
        do @(posedge aclk); while (!s_tready);
        if (row.known) begin
            push_pattern(row);
        end else begin
            chase_frame(row.value);
        end
    endtask

    // Stops offering and waits until every expected color has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (colors_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compares each color transfer with the oldest expected one.
    always @(posedge aclk) begin
        led_px_t got;
        led_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx   = m_tdata[5:0];
            got.red   = m_tdata[13:6];
            got.green = m_tdata[21:14];
            got.blue  = m_tdata[29:22];
            got.last  = m_tlast;
            if (colors_due.size() == 0) begin
                if (bad_count < MAX_REPORTS) begin
                    $display("unexpected color: led %0d rgb %h%h%h last %b",
                             got.idx, got.red, got.green, got.blue, got.last);
                end
                bad_count++;
            end else begin
                want = colors_due.pop_front();
                if (got != want) begin
                    if (bad_count < MAX_REPORTS) begin
                        $display("color mismatch: expected led %0d rgb %h%h%h last %b",
                                 want.idx, want.red, want.green, want.blue, want.last);
                        $display("                got      led %0d rgb %h%h%h last %b",
                                 got.idx, got.red, got.green, got.blue, got.last);
                    end
                    bad_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [WORD_W-1:0] t;
        int                pick;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan: defaults after reset, count limits, a single LED,
        // head at LED zero, zero and full speed, wrapping sums, spare indexes.
        plan = '{
            known_row(32'h0000_0000, 7'd60, 6'd0, 24'h000000, 6'd59, 24'hFFFFFF, 24'h000000),
            frame_row(32'hFFFF_FFFF),
            frame_row(32'h0000_8000),
            reg_row(CFG_LED_COUNT, 32'd1),
            known_row(32'h0000_0000, 7'd1, 6'd0, 24'h000000, 6'd0, 24'h000000, 24'h000000),
            known_row(32'h0000_8000, 7'd1, 6'd0, 24'h808080, 6'd0, 24'h808080, 24'h000000),
            known_row(32'h0000_FFFF, 7'd1, 6'd0, 24'hFFFFFF, 6'd0, 24'hFFFFFF, 24'h000000),
            reg_row(CFG_LED_COUNT, 32'd0),
            known_row(32'h0000_4000, 7'd1, 6'd0, 24'h404040, 6'd0, 24'h404040, 24'h000000),
            reg_row(CFG_LED_COUNT, 32'hFFFF_FFFF),
            frame_row(32'h0000_C000),
            reg_row(CFG_LED_COUNT, 32'd64),
            known_row(32'h0000_0000, 7'd64, 6'd0, 24'h000000, 6'd63, 24'hFFFFFF, 24'h000000),
            reg_row(CFG_LED_COUNT, 32'd2),
            frame_row(32'h0000_8000),
            frame_row(32'h0000_0000),
            reg_row(CFG_SPEED, 32'h0),
            known_row(32'hFFFF_FFFF, 7'd2, 6'd0, 24'h000000, 6'd1, 24'hFFFFFF, 24'h000000),
            reg_row(CFG_SPEED, 32'hFFFF_FFFF),
            reg_row(CFG_PHASE, 32'hFFFF_FFFF),
            reg_row(CFG_HEAD_COLOR, 32'hFF12_3456),
            reg_row(CFG_TAIL_COLOR, 32'h00AB_CDEF),
            reg_row(CFG_BG_COLOR, 32'h0000_FF00),
            reg_row(CFG_LED_COUNT, 32'd17),
            frame_row(32'h0000_0000),
            frame_row(32'h0000_0001),
            frame_row(32'hFFFF_FFFF),
            frame_row(32'h8000_0000),
            reg_row(CFG_SPARE_6, 32'h0),
            reg_row(CFG_SPARE_7, 32'hFFFF_FFFF),
            frame_row(32'h1234_5678)
        };
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_frame(plan[i]);
            end
        end

        // Random phases: fresh settings each time, then a run of frames that
        // mostly advance like an animation and sometimes jump anywhere.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            pick = $urandom_range(3);
            write_reg(CFG_SPEED, (pick == 0) ? 32'hFFFF_FFFF :
                                 (pick == 1) ? 32'h0 : $urandom);
            write_reg(CFG_PHASE, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
            pick = $urandom_range(9);
            write_reg(CFG_LED_COUNT, (pick == 0) ? $urandom :
                                     (pick == 1) ? 32'd64 :
                                     (pick == 2) ? 32'd1 : $urandom_range(LED_MAX, 1));
            write_reg(CFG_HEAD_COLOR, pick_color());
            write_reg(CFG_TAIL_COLOR, pick_color());
            write_reg(CFG_BG_COLOR, pick_color());
            // The first phase starts with a long receiver hold-off so that the
            // block fills up; the second runs with no gaps on either side.
            if (ph == 0) hold_ask <= hold_ask + 1;
            idle_on <= (ph != 1);
            t = $urandom;
            for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
                if ($urandom_range(9) < 7) begin
                    t = t + $urandom_range(32'h0000_2000);
                end else begin
                    t = $urandom;
                end
                send_frame(frame_row(t));
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (colors_due.size() != 0) bad_count++;
        if (bad_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/lpcb_pkg.sv
src/lpcb_regs.sv
src/lpcb_front.sv
src/lpcb_queue.sv
src/lpcb_back.sv
src/led_progress_chaser_blend_top.sv
src/lpcb_checker.sv
dv/tb_top.sv
